### rtl/core/cobs_frame_ring_buffer_defines.svh
// Assertion macros for the COBS frame ring buffer.
// Used by the top level; expects signals clk and arst_n in scope.
`ifndef COBS_FRAME_RING_BUFFER_DEFINES_SVH
`define COBS_FRAME_RING_BUFFER_DEFINES_SVH

// Same-cycle implication, checked out of reset.
`define CFRB_ASSERT_IMP(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("cobs frame ring buffer check failed");

// Next-cycle implication, checked out of reset.
`define CFRB_ASSERT_NEXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("cobs frame ring buffer check failed");

`endif

### rtl/core/cfrb_pkg.sv
// Shared types and codes of the COBS frame ring buffer.
// No dependencies.
package cfrb_pkg;

	localparam logic REQ_WRITE = 1'b0;
	localparam logic REQ_READ  = 1'b1;

	localparam logic [1:0] KIND_WACK   = 2'd0;
	localparam logic [1:0] KIND_DATA   = 2'd1;
	localparam logic [1:0] KIND_STATUS = 2'd2;

	localparam logic [1:0] ST_OK         = 2'd0;
	localparam logic [1:0] ST_NONE       = 2'd1;
	localparam logic [1:0] ST_INCOMPLETE = 2'd2;
	localparam logic [1:0] ST_FORMAT     = 2'd3;

	localparam logic [7:0] CODE_FULL = 8'hff;

	// Classified command between front and back
	typedef struct packed {
		logic       is_read;
		logic [7:0] wr_byte;
		logic       batch_first;
		logic [8:0] batch_len;
		logic [5:0] cap;
	} cmd_t;

	typedef struct packed {
		logic [1:0] kind;
		logic [7:0] data_byte;
		logic       accepted;
		logic [1:0] read_status;
		logic [5:0] frame_len;
		logic       is_last;
		logic [8:0] stored_count;
	} rsp_t;

endpackage

### rtl/core/cfrb_front.sv
// Front stage: accepts request words, clamps the read capacity and
// registers a classified command. Depends on cfrb_pkg.
module cfrb_front #(
	parameter int MAX_OUT = 63
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          req_valid,
	output logic          req_ready,
	input  logic          req_type,
	input  logic [7:0]    wr_byte,
	input  logic          batch_first,
	input  logic [8:0]    batch_len,
	input  logic [5:0]    out_capacity,
	output logic          cmd_valid,
	output cfrb_pkg::cmd_t cmd,
	input  logic          cmd_ready
);

	logic           v_s1;
	cfrb_pkg::cmd_t cmd_s1;
	cfrb_pkg::cmd_t cmd_new;
	logic           take;

	always_comb begin
		cmd_new.is_read     = (req_type == cfrb_pkg::REQ_READ);
		cmd_new.wr_byte     = wr_byte;
		cmd_new.batch_first = batch_first;
		cmd_new.batch_len   = batch_len;
		cmd_new.cap         = (out_capacity > 6'(MAX_OUT)) ? 6'(MAX_OUT) : out_capacity;
	end

	assign req_ready = !v_s1 || cmd_ready;
	assign take      = req_valid && req_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else if (take) begin
			v_s1 <= 1'b1;
		end else if (cmd_ready) begin
			v_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (take) begin
			cmd_s1 <= cmd_new;
		end
	end

	assign cmd_valid = v_s1;
	assign cmd       = cmd_s1;

endmodule

### rtl/core/cfrb_queue.sv
// Two-entry command queue between front and back.
// Depends on cfrb_pkg.
module cfrb_queue (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           push_valid,
	output logic           push_ready,
	input  cfrb_pkg::cmd_t push_cmd,
	output logic           pop_valid,
	input  logic           pop,
	output cfrb_pkg::cmd_t pop_cmd
);

	cfrb_pkg::cmd_t entry_q [0:1];
	logic           wr_ptr_q;
	logic           rd_ptr_q;
	logic [1:0]     count_q;
	logic           do_push;
	logic           do_pop;

	assign push_ready = (count_q != 2'd2);
	assign pop_valid  = (count_q != 2'd0);
	assign pop_cmd    = entry_q[rd_ptr_q];
	assign do_push    = push_valid && push_ready;
	assign do_pop     = pop && pop_valid;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			count_q  <= 2'd0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= !wr_ptr_q;
			end
			if (do_pop) begin
				rd_ptr_q <= !rd_ptr_q;
			end
			if (do_push && !do_pop) begin
				count_q <= count_q + 2'd1;
			end else if (do_pop && !do_push) begin
				count_q <= count_q - 2'd1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (do_push) begin
			entry_q[wr_ptr_q] <= push_cmd;
		end
	end

endmodule

### rtl/core/cfrb_back.sv
// Back end: byte store, write/batch bookkeeping, COBS frame walk, decoded
// byte buffer and result register. Depends on cfrb_pkg.
module cfrb_back #(
	parameter int DEPTH   = 256,
	parameter int MAX_OUT = 63
) (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           cmd_valid,
	input  cfrb_pkg::cmd_t cmd,
	output logic           cmd_pop,
	output logic           rsp_valid,
	input  logic           rsp_ready,
	output cfrb_pkg::rsp_t rsp
);

	localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CW   = $clog2(DEPTH + 1);
	localparam int SW   = ((CW > 9) ? CW : 9) + 1;
	localparam int BW   = (MAX_OUT > 1) ? $clog2(MAX_OUT) : 1;
	localparam int DB_N = 1 << BW;

	localparam logic [1:0] S_IDLE = 2'd0;
	localparam logic [1:0] S_WALK = 2'd1;
	localparam logic [1:0] S_EMIT = 2'd2;

	logic [7:0] store_mem [0:DEPTH-1];
	logic [7:0] dbuf_mem  [0:DB_N-1];

	logic [1:0]    state_q, state_d;
	logic [AW-1:0] rp_q, rp_d, wp_q, wp_d, pos_q, pos_d, pos_inc, store_addr;
	logic [CW-1:0] total_q, total_d, fp_q, fp_d, walked_q, walked_d, wr_total;
	logic          rej_q, rej_d, rej_n, wr_acc;
	logic [5:0]    cap_q, cap_d, emitted_q, emitted_d, emit_idx_q, emit_idx_d;
	logic [7:0]    block_q, block_d;
	logic          code_ff_q, code_ff_d;
	logic [1:0]    st_q, st_d;
	logic [5:0]    flen_q, flen_d;
	logic [7:0]    store_rd_q, dbuf_rd_q, b;
	logic          store_we, db_we;
	logic [7:0]    db_wdata;
	logic          out_free, rsp_load;
	logic          rsp_valid_q;
	cfrb_pkg::rsp_t rsp_q, rsp_d;
	logic [CW+8:0] wr_ext, cur_ext;

	assign out_free = !rsp_valid_q || rsp_ready;
	assign pos_inc  = (pos_q == AW'(DEPTH - 1)) ? '0 : pos_q + AW'(1);
	assign b        = store_rd_q;

	always_comb begin
		rej_n    = cmd.batch_first
			? ((SW'(cmd.batch_len) + SW'(total_q)) > SW'(DEPTH)) : rej_q;
		wr_acc   = !rej_n && (total_q != CW'(DEPTH));
		wr_total = wr_acc ? total_q + CW'(1) : total_q;
		wr_ext   = {9'd0, wr_total};
		cur_ext  = {9'd0, total_q};
	end

	always_comb begin
		state_d    = state_q;
		rp_d       = rp_q;
		wp_d       = wp_q;
		pos_d      = pos_q;
		total_d    = total_q;
		fp_d       = fp_q;
		walked_d   = walked_q;
		rej_d      = rej_q;
		cap_d      = cap_q;
		emitted_d  = emitted_q;
		emit_idx_d = emit_idx_q;
		block_d    = block_q;
		code_ff_d  = code_ff_q;
		st_d       = st_q;
		flen_d     = flen_q;
		cmd_pop    = 1'b0;
		store_we   = 1'b0;
		db_we      = 1'b0;
		db_wdata   = b;
		rsp_load   = 1'b0;
		rsp_d      = rsp_q;

		unique case (state_q)
			S_IDLE: begin
				if (cmd_valid && out_free) begin
					cmd_pop = 1'b1;
					if (!cmd.is_read) begin
						rej_d = rej_n;
						if (wr_acc) begin
							store_we = 1'b1;
							wp_d     = (wp_q == AW'(DEPTH - 1)) ? '0 : wp_q + AW'(1);
							total_d  = wr_total;
							fp_d     = fp_q + CW'(cmd.wr_byte == 8'd0);
						end
						rsp_load           = 1'b1;
						rsp_d.kind         = cfrb_pkg::KIND_WACK;
						rsp_d.data_byte    = 8'd0;
						rsp_d.accepted     = wr_acc;
						rsp_d.read_status  = cfrb_pkg::ST_OK;
						rsp_d.frame_len    = 6'd0;
						rsp_d.is_last      = 1'b1;
						rsp_d.stored_count = wr_ext[8:0];
					end else if (total_q == '0 || fp_q == '0) begin
						rsp_load           = 1'b1;
						rsp_d.kind         = cfrb_pkg::KIND_STATUS;
						rsp_d.data_byte    = 8'd0;
						rsp_d.accepted     = 1'b0;
						rsp_d.read_status  = cfrb_pkg::ST_NONE;
						rsp_d.frame_len    = 6'd0;
						rsp_d.is_last      = 1'b1;
						rsp_d.stored_count = cur_ext[8:0];
					end else begin
						// store_rd_q holds the byte at rp_q next cycle
						state_d   = S_WALK;
						pos_d     = rp_q;
						walked_d  = '0;
						emitted_d = 6'd0;
						block_d   = 8'd0;
						code_ff_d = 1'b1;
						cap_d     = cmd.cap;
					end
				end
			end
			S_WALK: begin
				if (emitted_q >= cap_q || walked_q >= total_q) begin
					// leave the store untouched
					st_d       = cfrb_pkg::ST_INCOMPLETE;
					flen_d     = 6'd0;
					emit_idx_d = 6'd0;
					state_d    = S_EMIT;
				end else if (b == 8'd0) begin
					// delimiter, or a zero inside a block: consume through it
					st_d       = (block_q == 8'd0) ? cfrb_pkg::ST_OK : cfrb_pkg::ST_FORMAT;
					flen_d     = (block_q == 8'd0) ? emitted_q : 6'd0;
					rp_d       = pos_inc;
					total_d    = total_q - walked_q - CW'(1);
					fp_d       = (fp_q != '0) ? fp_q - CW'(1) : fp_q;
					emit_idx_d = 6'd0;
					state_d    = S_EMIT;
				end else begin
					if (block_q != 8'd0) begin
						db_we     = 1'b1;
						db_wdata  = b;
						emitted_d = emitted_q + 6'd1;
						block_d   = block_q - 8'd1;
					end else begin
						// new code byte; a zero stands between blocks unless after 0xff
						if (!code_ff_q) begin
							db_we     = 1'b1;
							db_wdata  = 8'd0;
							emitted_d = emitted_q + 6'd1;
						end
						code_ff_d = (b == cfrb_pkg::CODE_FULL);
						block_d   = b - 8'd1;
					end
					pos_d    = pos_inc;
					walked_d = walked_q + CW'(1);
				end
			end
			S_EMIT: begin
				if (out_free) begin
					rsp_load           = 1'b1;
					rsp_d.accepted     = 1'b0;
					rsp_d.stored_count = cur_ext[8:0];
					if (emit_idx_q != emitted_q) begin
						rsp_d.kind        = cfrb_pkg::KIND_DATA;
						rsp_d.data_byte   = dbuf_rd_q;
						rsp_d.read_status = cfrb_pkg::ST_OK;
						rsp_d.frame_len   = 6'd0;
						rsp_d.is_last     = 1'b0;
						emit_idx_d        = emit_idx_q + 6'd1;
					end else begin
						rsp_d.kind        = cfrb_pkg::KIND_STATUS;
						rsp_d.data_byte   = 8'd0;
						rsp_d.read_status = st_q;
						rsp_d.frame_len   = flen_q;
						rsp_d.is_last     = 1'b1;
						state_d           = S_IDLE;
					end
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	assign store_addr = (state_q == S_WALK) ? pos_inc : rp_q;

	always_ff @(posedge clk) begin
		if (store_we) begin
			store_mem[wp_q] <= cmd.wr_byte;
		end
		store_rd_q <= store_mem[store_addr];
	end

	always_ff @(posedge clk) begin
		if (db_we) begin
			dbuf_mem[emitted_q[BW-1:0]] <= db_wdata;
		end
		dbuf_rd_q <= dbuf_mem[emit_idx_d[BW-1:0]];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			rp_q        <= '0;
			wp_q        <= '0;
			total_q     <= '0;
			fp_q        <= '0;
			rej_q       <= 1'b0;
			rsp_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			rp_q    <= rp_d;
			wp_q    <= wp_d;
			total_q <= total_d;
			fp_q    <= fp_d;
			rej_q   <= rej_d;
			if (rsp_load) begin
				rsp_valid_q <= 1'b1;
			end else if (rsp_ready) begin
				rsp_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		pos_q      <= pos_d;
		walked_q   <= walked_d;
		cap_q      <= cap_d;
		emitted_q  <= emitted_d;
		emit_idx_q <= emit_idx_d;
		block_q    <= block_d;
		code_ff_q  <= code_ff_d;
		st_q       <= st_d;
		flen_q     <= flen_d;
		if (rsp_load) begin
			rsp_q <= rsp_d;
		end
	end

	assign rsp_valid = rsp_valid_q;
	assign rsp       = rsp_q;

endmodule

### rtl/core/cobs_frame_ring_buffer.sv
// Write word: one per cycle sustained while rsp_ready holds; acknowledge is registered.
// Read word: W stored bytes walked at one per cycle through the
// byte store read port, then E decoded bytes replayed from the decode buffer.
// Reset (arst_n, async, active low) clears pointers, counts and handshakes at once;
// byte store contents stay undefined until written, no clearing pass.
`include "cobs_frame_ring_buffer_defines.svh"

module cobs_frame_ring_buffer #(
	parameter int DEPTH   = 256,
	parameter int MAX_OUT = 63
) (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       req_valid,
	output logic       req_ready,
	input  logic       req_type,
	input  logic [7:0] wr_byte,
	input  logic       batch_first,
	input  logic [8:0] batch_len,
	input  logic [5:0] out_capacity,
	output logic       rsp_valid,
	input  logic       rsp_ready,
	output logic [1:0] kind,
	output logic [7:0] data_byte,
	output logic       accepted,
	output logic [1:0] read_status,
	output logic [5:0] frame_len,
	output logic       is_last,
	output logic [8:0] stored_count
);

	logic           f_valid, f_ready;
	cfrb_pkg::cmd_t f_cmd;
	logic           q_valid, q_pop;
	cfrb_pkg::cmd_t q_cmd;
	cfrb_pkg::rsp_t rsp;

	cfrb_front #(
		.MAX_OUT(MAX_OUT)
	) u_front (
		.clk         (clk),
		.arst_n      (arst_n),
		.req_valid   (req_valid),
		.req_ready   (req_ready),
		.req_type    (req_type),
		.wr_byte     (wr_byte),
		.batch_first (batch_first),
		.batch_len   (batch_len),
		.out_capacity(out_capacity),
		.cmd_valid   (f_valid),
		.cmd         (f_cmd),
		.cmd_ready   (f_ready)
	);

	cfrb_queue u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push_valid(f_valid),
		.push_ready(f_ready),
		.push_cmd  (f_cmd),
		.pop_valid (q_valid),
		.pop       (q_pop),
		.pop_cmd   (q_cmd)
	);

	cfrb_back #(
		.DEPTH  (DEPTH),
		.MAX_OUT(MAX_OUT)
	) u_back (
		.clk      (clk),
		.arst_n   (arst_n),
		.cmd_valid(q_valid),
		.cmd      (q_cmd),
		.cmd_pop  (q_pop),
		.rsp_valid(rsp_valid),
		.rsp_ready(rsp_ready),
		.rsp      (rsp)
	);

	assign kind         = rsp.kind;
	assign data_byte    = rsp.data_byte;
	assign accepted     = rsp.accepted;
	assign read_status  = rsp.read_status;
	assign frame_len    = rsp.frame_len;
	assign is_last      = rsp.is_last;
	assign stored_count = rsp.stored_count;

	// only decoded bytes leave a word open
	`CFRB_ASSERT_IMP(a_last_kind, rsp_valid, is_last == (kind != cfrb_pkg::KIND_DATA))
	`CFRB_ASSERT_IMP(a_flen_ok, rsp_valid && frame_len != 6'd0,
		kind == cfrb_pkg::KIND_STATUS && read_status == cfrb_pkg::ST_OK)
	`CFRB_ASSERT_IMP(a_data_clean, rsp_valid && kind == cfrb_pkg::KIND_DATA,
		!accepted && read_status == cfrb_pkg::ST_OK && frame_len == 6'd0)
	// replay never bubbles once a decoded byte is taken
	`CFRB_ASSERT_NEXT(a_replay_flow, rsp_valid && rsp_ready && kind == cfrb_pkg::KIND_DATA,
		rsp_valid)

endmodule
